@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// No dependencies; every macro takes its clock and active-low reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/gcs_pkg.sv @@
// Shared types and codes of the clip stack command processor.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package gcs_pkg;

    // Command opcodes
    localparam logic [2:0] OP_BEGIN  = 3'd0;
    localparam logic [2:0] OP_PUSH   = 3'd1;
    localparam logic [2:0] OP_POP    = 3'd2;
    localparam logic [2:0] OP_FILL   = 3'd3;
    localparam logic [2:0] OP_STROKE = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_QUAD    = 2'd0;
    localparam logic [1:0] KIND_SET     = 2'd1;
    localparam logic [1:0] KIND_DISABLE = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Result status
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

    // Configuration register indexes
    localparam logic CFG_FRAME_W = 1'b0;
    localparam logic CFG_FRAME_H = 1'b1;

    localparam int unsigned CFG_W   = 14;

    localparam logic [1:0] STROKE_LAST_BEAT = 2'd3;

    typedef struct packed {
        logic signed [15:0] min_x;
        logic signed [15:0] min_y;
        logic signed [15:0] max_x;
        logic signed [15:0] max_y;
    } t_rect;

    // Controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       rd_en;
        logic       clip_en;
        logic       emit;
        logic       last;
        logic [1:0] beat;
        logic [2:0] op;
    } t_dp_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic one;
    } t_dp_sts;

endpackage

@@ hdl/gui_clip_stack_command_processor_unit.sv @@
// Top level of the clip stack command processor: sequencer plus datapath.
// Depends on gcs_pkg, gcs_ctrl and gcs_datapath.
//
// Usage:
//   Commands: drive the command fields and raise start; a command is taken at
//   a rising edge where start is high and busy is low. busy stays high while
//   the command is worked on and drops in the cycle its last result shows.
//   Results: each result beat is on the o_ ports for one cycle with o_valid
//   high; o_last marks the final beat of a command. The receiver cannot stall.
//   Configuration: i_cfg_we, i_cfg_idx (0 width, 1 height), i_cfg_data; write
//   only while busy is low and no result is still due.
// States passed after the accept edge, before the result register shows a beat:
//   begin frame, filled rect, rejected push/pop, pop to empty: S_EMIT only
//   pop with a scissor to restore: S_FETCH (one stack memory read), S_EMIT
//   push: S_FETCH (stack read), S_CLIP (intersect), S_EMIT (scissor arithmetic)
//   stroked rect: S_EMIT, one edge quad per cycle: top, bottom, left, right
//   opcodes 5..7: taken and dropped, busy never rises.
// The next command can be taken in the cycle the last beat shows.
// Reset: stack empty, scissor state gone, frame 1920x1080, no beat pending.
module gui_clip_stack_command_processor_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [gcs_pkg::CFG_W-1:0] i_cfg_data,
    input  logic [2:0]                i_opcode,
    input  logic signed [15:0]        i_min_x,
    input  logic signed [15:0]        i_min_y,
    input  logic signed [15:0]        i_max_x,
    input  logic signed [15:0]        i_max_y,
    input  logic [31:0]               i_color,
    input  logic [7:0]                i_thick_top,
    input  logic [7:0]                i_thick_bottom,
    input  logic [7:0]                i_thick_left,
    input  logic [7:0]                i_thick_right,
    output logic                      o_valid,
    output logic [1:0]                o_kind,
    output logic signed [15:0]        o_out_a,
    output logic signed [15:0]        o_out_b,
    output logic signed [15:0]        o_out_c,
    output logic signed [15:0]        o_out_d,
    output logic [31:0]               o_out_color,
    output logic [1:0]                o_status,
    output logic                      o_last
);

    gcs_pkg::t_dp_ctl ctl;
    gcs_pkg::t_dp_sts sts;

    // Sequencer: decides per opcode which datapath steps run and how many beats go out
    gcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .busy     (busy),
        .o_ctl    (ctl)
    );

    // Datapath: stack memory, clipping, scissor and edge arithmetic, result register
    gcs_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_min_x        (i_min_x),
        .i_min_y        (i_min_y),
        .i_max_x        (i_max_x),
        .i_max_y        (i_max_y),
        .i_color        (i_color),
        .i_thick_top    (i_thick_top),
        .i_thick_bottom (i_thick_bottom),
        .i_thick_left   (i_thick_left),
        .i_thick_right  (i_thick_right),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_out_a        (o_out_a),
        .o_out_b        (o_out_b),
        .o_out_c        (o_out_c),
        .o_out_d        (o_out_d),
        .o_out_color    (o_out_color),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

@@ hdl/gcs_ctrl.sv @@
// Command sequencer of the clip stack command processor.
// Depends on gcs_pkg for opcodes and the controller/datapath structs.
module gcs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [2:0]       i_opcode,
    input  gcs_pkg::t_dp_sts i_sts,
    output logic             busy,
    output gcs_pkg::t_dp_ctl o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_CLIP  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_op, n_op;
    logic [1:0] r_beat, n_beat;
    logic       emit_last;

    assign busy      = (r_state != S_IDLE);
    assign emit_last = (r_op != gcs_pkg::OP_STROKE) || (r_beat == gcs_pkg::STROKE_LAST_BEAT);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_beat  = r_beat;
        o_ctl   = '0;
        o_ctl.op   = r_op;
        o_ctl.beat = r_beat;
        case (r_state)
            S_IDLE: begin
                n_beat = 2'd0;
                if (start) begin
                    o_ctl.capture = 1'b1;
                    n_op          = i_opcode;
                    case (i_opcode)
                        gcs_pkg::OP_BEGIN,
                        gcs_pkg::OP_FILL,
                        gcs_pkg::OP_STROKE: n_state = S_EMIT;
                        gcs_pkg::OP_PUSH:   n_state = i_sts.full ? S_EMIT : S_FETCH;
                        gcs_pkg::OP_POP:    n_state = (i_sts.empty || i_sts.one) ? S_EMIT
                                                                                 : S_FETCH;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_FETCH: begin
                o_ctl.rd_en = 1'b1;
                n_state     = (r_op == gcs_pkg::OP_PUSH) ? S_CLIP : S_EMIT;
            end
            S_CLIP: begin
                o_ctl.clip_en = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                o_ctl.emit = 1'b1;
                o_ctl.last = emit_last;
                if (emit_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_beat = r_beat + 2'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= gcs_pkg::OP_BEGIN;
            r_beat  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_beat  <= n_beat;
        end
    end

endmodule

@@ hdl/gcs_datapath.sv @@
// Datapath of the clip stack command processor: frame registers, clip stack memory,
// clipping and quad arithmetic, result register. Depends on gcs_pkg.
module gcs_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gcs_pkg::t_dp_ctl             i_ctl,
    output gcs_pkg::t_dp_sts             o_sts,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [gcs_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic signed [15:0]           i_min_x,
    input  logic signed [15:0]           i_min_y,
    input  logic signed [15:0]           i_max_x,
    input  logic signed [15:0]           i_max_y,
    input  logic [31:0]                  i_color,
    input  logic [7:0]                   i_thick_top,
    input  logic [7:0]                   i_thick_bottom,
    input  logic [7:0]                   i_thick_left,
    input  logic [7:0]                   i_thick_right,
    output logic                         o_valid,
    output logic [1:0]                   o_kind,
    output logic signed [15:0]           o_out_a,
    output logic signed [15:0]           o_out_b,
    output logic signed [15:0]           o_out_c,
    output logic signed [15:0]           o_out_d,
    output logic [31:0]                  o_out_color,
    output logic [1:0]                   o_status,
    output logic                         o_last
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    gcs_pkg::t_rect mem [STACK_DEPTH];

    logic [gcs_pkg::CFG_W-1:0] r_fw, r_fh;
    logic [DW-1:0]             r_depth, n_depth;

    // Latched command
    logic signed [15:0] r_x0, r_y0, r_x1, r_y1;
    logic [31:0]        r_color;
    logic [7:0]         r_tt, r_tb, r_tl, r_tr;

    gcs_pkg::t_rect r_pre, n_pre;
    gcs_pkg::t_rect r_clip, n_clip;
    gcs_pkg::t_rect r_rd;

    logic [DW-1:0] rd_ptr;
    logic          mem_we;

    // Result register
    logic               r_valid, r_last;
    logic [1:0]         r_kind, n_kind;
    logic signed [15:0] r_a, r_b, r_c, r_d, n_a, n_b, n_c, n_d;
    logic [31:0]        r_ocolor, n_ocolor;
    logic [1:0]         r_status, n_status;

    // Scissor and stroke arithmetic
    gcs_pkg::t_rect     sc;
    logic signed [15:0] sc_b, sc_c, sc_d;
    logic signed [16:0] top_sum, bot_dif, lft_sum, rgt_dif;
    logic signed [15:0] top_d, bot_b, lft_c, rgt_a;
    logic signed [15:0] t_x0, t_y0, t_x1, t_y1;

    assign o_sts.full  = (r_depth == DW'(STACK_DEPTH));
    assign o_sts.empty = (r_depth == '0);
    assign o_sts.one   = (r_depth == DW'(1));

    // Frame registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= gcs_pkg::CFG_W'(1920);
            r_fh <= gcs_pkg::CFG_W'(1080);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gcs_pkg::CFG_FRAME_W: r_fw <= i_cfg_data;
                gcs_pkg::CFG_FRAME_H: r_fh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clip against the framebuffer while taking the command
    always_comb begin
        n_pre.min_x = (i_min_x < 16'sd0) ? 16'sd0 : i_min_x;
        n_pre.min_y = (i_min_y < 16'sd0) ? 16'sd0 : i_min_y;
        n_pre.max_x = ($signed({i_max_x[15], i_max_x}) < $signed({3'b000, r_fw}))
                      ? i_max_x : $signed({2'b00, r_fw});
        n_pre.max_y = ($signed({i_max_y[15], i_max_y}) < $signed({3'b000, r_fh}))
                      ? i_max_y : $signed({2'b00, r_fh});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_x0    <= i_min_x;
            r_y0    <= i_min_y;
            r_x1    <= i_max_x;
            r_y1    <= i_max_y;
            r_color <= i_color;
            r_tt    <= i_thick_top;
            r_tb    <= i_thick_bottom;
            r_tl    <= i_thick_left;
            r_tr    <= i_thick_right;
            r_pre   <= n_pre;
        end
    end

    // Push reads the current top, pop reads the one below it
    assign rd_ptr = (i_ctl.op == gcs_pkg::OP_PUSH) ? (r_depth - DW'(1)) : (r_depth - DW'(2));

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd <= mem[rd_ptr[AW-1:0]];
        end
        if (mem_we) begin
            mem[r_depth[AW-1:0]] <= r_clip;
        end
    end

    // Intersect with the stack top, then keep max not below min
    always_comb begin
        t_x0 = (!o_sts.empty && (r_rd.min_x > r_pre.min_x)) ? r_rd.min_x : r_pre.min_x;
        t_y0 = (!o_sts.empty && (r_rd.min_y > r_pre.min_y)) ? r_rd.min_y : r_pre.min_y;
        t_x1 = (!o_sts.empty && (r_rd.max_x < r_pre.max_x)) ? r_rd.max_x : r_pre.max_x;
        t_y1 = (!o_sts.empty && (r_rd.max_y < r_pre.max_y)) ? r_rd.max_y : r_pre.max_y;
        n_clip.min_x = t_x0;
        n_clip.min_y = t_y0;
        n_clip.max_x = (t_x1 < t_x0) ? t_x0 : t_x1;
        n_clip.max_y = (t_y1 < t_y0) ? t_y0 : t_y1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clip_en) begin
            r_clip <= n_clip;
        end
    end

    // Scissor from a stored rectangle; y counts from the frame bottom
    assign sc   = (i_ctl.op == gcs_pkg::OP_PUSH) ? r_clip : r_rd;
    assign sc_b = $signed({2'b00, r_fh}) - sc.max_y;
    assign sc_c = sc.max_x - sc.min_x;
    assign sc_d = sc.max_y - sc.min_y;

    // Stroke edges
    assign top_sum = $signed({r_y0[15], r_y0}) + $signed({9'b0, r_tt});
    assign bot_dif = $signed({r_y1[15], r_y1}) - $signed({9'b0, r_tb});
    assign lft_sum = $signed({r_x0[15], r_x0}) + $signed({9'b0, r_tl});
    assign rgt_dif = $signed({r_x1[15], r_x1}) - $signed({9'b0, r_tr});
    assign top_d = (top_sum < $signed({r_y1[15], r_y1})) ? top_sum[15:0] : r_y1;
    assign bot_b = (bot_dif > $signed({r_y0[15], r_y0})) ? bot_dif[15:0] : r_y0;
    assign lft_c = (lft_sum < $signed({r_x1[15], r_x1})) ? lft_sum[15:0] : r_x1;
    assign rgt_a = (rgt_dif > $signed({r_x0[15], r_x0})) ? rgt_dif[15:0] : r_x0;

    always_comb begin
        n_kind   = gcs_pkg::KIND_ERROR;
        n_a      = '0;
        n_b      = '0;
        n_c      = '0;
        n_d      = '0;
        n_ocolor = '0;
        n_status = gcs_pkg::STAT_OK;
        n_depth  = r_depth;
        mem_we   = 1'b0;
        if (i_ctl.emit) begin
            case (i_ctl.op)
                gcs_pkg::OP_BEGIN: begin
                    n_kind  = gcs_pkg::KIND_DISABLE;
                    n_depth = '0;
                end
                gcs_pkg::OP_PUSH: begin
                    if (o_sts.full) begin
                        n_status = gcs_pkg::STAT_OVERFLOW;
                    end else begin
                        n_kind  = gcs_pkg::KIND_SET;
                        n_a     = sc.min_x;
                        n_b     = sc_b;
                        n_c     = sc_c;
                        n_d     = sc_d;
                        mem_we  = 1'b1;
                        n_depth = r_depth + DW'(1);
                    end
                end
                gcs_pkg::OP_POP: begin
                    if (o_sts.empty) begin
                        n_status = gcs_pkg::STAT_UNDERFLOW;
                    end else begin
                        n_depth = r_depth - DW'(1);
                        if (o_sts.one) begin
                            n_kind = gcs_pkg::KIND_DISABLE;
                        end else begin
                            n_kind = gcs_pkg::KIND_SET;
                            n_a    = sc.min_x;
                            n_b    = sc_b;
                            n_c    = sc_c;
                            n_d    = sc_d;
                        end
                    end
                end
                gcs_pkg::OP_FILL: begin
                    n_kind   = gcs_pkg::KIND_QUAD;
                    n_a      = r_x0;
                    n_b      = r_y0;
                    n_c      = r_x1;
                    n_d      = r_y1;
                    n_ocolor = r_color;
                end
                gcs_pkg::OP_STROKE: begin
                    n_kind   = gcs_pkg::KIND_QUAD;
                    n_a      = r_x0;
                    n_b      = r_y0;
                    n_c      = r_x1;
                    n_d      = r_y1;
                    n_ocolor = r_color;
                    case (i_ctl.beat)
                        2'd0:    n_d = top_d;
                        2'd1:    n_b = bot_b;
                        2'd2:    n_c = lft_c;
                        default: n_a = rgt_a;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_depth <= n_depth;
            r_valid <= i_ctl.emit;
            r_last  <= i_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_a      <= n_a;
        r_b      <= n_b;
        r_c      <= n_c;
        r_d      <= n_d;
        r_ocolor <= n_ocolor;
        r_status <= n_status;
    end

    assign o_valid     = r_valid;
    assign o_last      = r_last;
    assign o_kind      = r_kind;
    assign o_out_a     = r_a;
    assign o_out_b     = r_b;
    assign o_out_c     = r_c;
    assign o_out_d     = r_d;
    assign o_out_color = r_ocolor;
    assign o_status    = r_status;

endmodule

@@ hdl/gcs_checker.sv @@
// Port-level checker for the clip stack command processor, bound to the top level.
// Depends on gcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gcs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [2:0] i_opcode,
    input logic       o_valid,
    input logic [1:0] o_kind,
    input logic       o_last
);

    logic accept;
    logic ignored_op;
    logic non_quad_beat;

    assign accept     = start && !busy;
    assign ignored_op = (i_opcode != gcs_pkg::OP_BEGIN) && (i_opcode != gcs_pkg::OP_PUSH) &&
                        (i_opcode != gcs_pkg::OP_POP) && (i_opcode != gcs_pkg::OP_FILL) &&
                        (i_opcode != gcs_pkg::OP_STROKE);
    assign non_quad_beat = o_valid && (o_kind != gcs_pkg::KIND_QUAD);

    // No beat can show in the cycle right after a command is taken
    `ASSERT_NEXT(a_no_beat_after_accept, i_clk, i_rst_n, accept, !o_valid, "beat right after accept")
    // The final beat frees the block; earlier beats of a stroke keep it busy
    `ASSERT_SAME(a_last_frees, i_clk, i_rst_n, o_valid && o_last, !busy, "busy at last beat")
    `ASSERT_SAME(a_mid_busy, i_clk, i_rst_n, o_valid && !o_last, busy, "idle mid command")
    // Only quads come in groups
    `ASSERT_SAME(a_single_non_quad, i_clk, i_rst_n, non_quad_beat, o_last, "non-quad not last")
    // Dropped opcodes never start work
    `ASSERT_NEXT(a_ignored_idle, i_clk, i_rst_n, accept && ignored_op, !busy, "ignored opcode made busy")

endmodule

bind gui_clip_stack_command_processor_unit gcs_checker u_gcs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_opcode (i_opcode),
    .o_valid  (o_valid),
    .o_kind   (o_kind),
    .o_last   (o_last)
);
